// File: hdl/vector_clock_tracker_defines.svh
// Assertion macros shared by the vector clock tracker RTL.
`ifndef VECTOR_CLOCK_TRACKER_DEFINES_SVH
`define VECTOR_CLOCK_TRACKER_DEFINES_SVH

// check a consequence in the same cycle
`define VCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a consequence in the following cycle
`define VCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vct_pkg.sv
// Shared types, operation codes and default sizes for the vector clock tracker.
package vct_pkg;

    localparam int DEF_THREADS    = 8;
    localparam int DEF_COND_SLOTS = 16;
    localparam int DEF_CLOCK_BITS = 32;

    typedef enum logic [2:0] {
        OP_JOIN   = 3'd0,
        OP_SIGNAL = 3'd1,
        OP_WAIT   = 3'd2,
        OP_CREATE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] actor_thread;
        logic [2:0] other_thread;
        logic [3:0] cond_slot;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  entry_thread;
        logic [31:0] clock_value;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic merge;
        logic bump;
        logic bump_twice;
    } row_ctl_t;

endpackage

// File: hdl/vct_state_mem.sv
// Clock table and signal store memories with per-row valid bits.
module vct_state_mem #(
    parameter int THREADS    = vct_pkg::DEF_THREADS,
    parameter int COND_SLOTS = vct_pkg::DEF_COND_SLOTS,
    parameter int CLOCK_BITS = vct_pkg::DEF_CLOCK_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ct_re,
    input  logic [$clog2(THREADS)-1:0]    ct_raddr_a,
    input  logic [$clog2(THREADS)-1:0]    ct_raddr_b,
    output logic [THREADS*CLOCK_BITS-1:0] ct_rdata_a,
    output logic [THREADS*CLOCK_BITS-1:0] ct_rdata_b,
    input  logic                          ct_we,
    input  logic [$clog2(THREADS)-1:0]    ct_waddr,
    input  logic [THREADS*CLOCK_BITS-1:0] ct_wdata,
    input  logic                          ss_re,
    input  logic [((COND_SLOTS > 1) ? $clog2(COND_SLOTS) : 1)-1:0] ss_raddr,
    output logic [THREADS*CLOCK_BITS-1:0] ss_rdata,
    input  logic                          ss_we,
    input  logic [((COND_SLOTS > 1) ? $clog2(COND_SLOTS) : 1)-1:0] ss_waddr,
    input  logic [THREADS*CLOCK_BITS-1:0] ss_wdata
);

    localparam int RW = THREADS * CLOCK_BITS;

    logic [RW-1:0]         ct_mem [THREADS];
    logic [RW-1:0]         ss_mem [COND_SLOTS];
    logic [THREADS-1:0]    ct_vld_reg;
    logic [THREADS-1:0]    ct_vld_next;
    logic [COND_SLOTS-1:0] ss_vld_reg;
    logic [COND_SLOTS-1:0] ss_vld_next;
    logic [RW-1:0]         ct_rd_a_reg;
    logic [RW-1:0]         ct_rd_b_reg;
    logic [RW-1:0]         ss_rd_reg;
    logic                  ct_hit_a_reg;
    logic                  ct_hit_a_next;
    logic                  ct_hit_b_reg;
    logic                  ct_hit_b_next;
    logic                  ss_hit_reg;
    logic                  ss_hit_next;

    always_comb
    begin
        ct_vld_next   = ct_vld_reg;
        ss_vld_next   = ss_vld_reg;
        ct_hit_a_next = ct_hit_a_reg;
        ct_hit_b_next = ct_hit_b_reg;
        ss_hit_next   = ss_hit_reg;
        if (ct_we)
        begin
            ct_vld_next[ct_waddr] = 1'b1;
        end
        if (ss_we)
        begin
            ss_vld_next[ss_waddr] = 1'b1;
        end
        if (ct_re)
        begin
            ct_hit_a_next = ct_vld_reg[ct_raddr_a];
            ct_hit_b_next = ct_vld_reg[ct_raddr_b];
        end
        if (ss_re)
        begin
            ss_hit_next = ss_vld_reg[ss_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_vld_reg   <= '0;
            ss_vld_reg   <= '0;
            ct_hit_a_reg <= 1'b0;
            ct_hit_b_reg <= 1'b0;
            ss_hit_reg   <= 1'b0;
        end
        else
        begin
            ct_vld_reg   <= ct_vld_next;
            ss_vld_reg   <= ss_vld_next;
            ct_hit_a_reg <= ct_hit_a_next;
            ct_hit_b_reg <= ct_hit_b_next;
            ss_hit_reg   <= ss_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            ct_mem[ct_waddr] <= ct_wdata;
        end
        if (ct_re)
        begin
            ct_rd_a_reg <= ct_mem[ct_raddr_a];
            ct_rd_b_reg <= ct_mem[ct_raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ss_we)
        begin
            ss_mem[ss_waddr] <= ss_wdata;
        end
        if (ss_re)
        begin
            ss_rd_reg <= ss_mem[ss_raddr];
        end
    end

    assign ct_rdata_a = ct_hit_a_reg ? ct_rd_a_reg : '0;
    assign ct_rdata_b = ct_hit_b_reg ? ct_rd_b_reg : '0;
    assign ss_rdata   = ss_hit_reg ? ss_rd_reg : '0;

endmodule

// File: hdl/vct_row_unit.sv
// Element-wise maximum and saturating increment of one entry over one clock row.
module vct_row_unit #(
    parameter int THREADS    = vct_pkg::DEF_THREADS,
    parameter int CLOCK_BITS = vct_pkg::DEF_CLOCK_BITS
) (
    input  vct_pkg::row_ctl_t             ctl,
    input  logic [$clog2(THREADS)-1:0]    bump_idx,
    input  logic [THREADS*CLOCK_BITS-1:0] row_a,
    input  logic [THREADS*CLOCK_BITS-1:0] row_b,
    output logic [THREADS*CLOCK_BITS-1:0] row_new
);

    localparam int TW = $clog2(THREADS);

    function automatic logic [CLOCK_BITS-1:0] sat_inc(input logic [CLOCK_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        logic [CLOCK_BITS-1:0] lane_a;
        logic [CLOCK_BITS-1:0] lane_b;
        logic [CLOCK_BITS-1:0] lane_m;
        row_new = '0;
        for (int i = 0; i < THREADS; i++)
        begin
            lane_a = row_a[i*CLOCK_BITS +: CLOCK_BITS];
            lane_b = row_b[i*CLOCK_BITS +: CLOCK_BITS];
            lane_m = (ctl.merge && (lane_b > lane_a)) ? lane_b : lane_a;
            if (ctl.bump && (bump_idx == TW'(i)))
            begin
                lane_m = sat_inc(lane_m);
                if (ctl.bump_twice)
                begin
                    lane_m = sat_inc(lane_m);
                end
            end
            row_new[i*CLOCK_BITS +: CLOCK_BITS] = lane_m;
        end
    end

endmodule

// File: hdl/vector_clock_tracker.sv
// Top level of the vector clock tracker: sequencer, memories and row unit.
//
//   channel | direction | word type            | handshake
//   req     | in        | vct_pkg::in_word_t   | req_valid / req_ready
//   rsp     | out       | vct_pkg::out_word_t  | rsp_valid / rsp_ready
//
// Join, signal, wait and self-create pass through S_EXEC; create of another
// thread also needs S_CREATE2, since the clock table has a single write port;
// read emits one entry per cycle in S_READ unless rsp stalls; unused codes
// go back to idle unanswered. The registered row read feeds the update in S_EXEC.
// Reset clears per-row valid bits at once; no clearing pass is needed.
// A stalled rsp holds the sequencer in its emitting state; req stays low.
`include "vector_clock_tracker_defines.svh"

module vector_clock_tracker #(
    parameter int THREADS    = vct_pkg::DEF_THREADS,
    parameter int COND_SLOTS = vct_pkg::DEF_COND_SLOTS,
    parameter int CLOCK_BITS = vct_pkg::DEF_CLOCK_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  vct_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output vct_pkg::out_word_t rsp_word
);

    localparam int TW = $clog2(THREADS);
    localparam int SW = (COND_SLOTS > 1) ? $clog2(COND_SLOTS) : 1;
    localparam int RW = THREADS * CLOCK_BITS;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXEC    = 4'b0010,
        S_CREATE2 = 4'b0100,
        S_READ    = 4'b1000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [2:0]         op_reg;
    logic [2:0]         op_next;
    logic [TW-1:0]      actor_reg;
    logic [TW-1:0]      actor_next;
    logic [TW-1:0]      other_reg;
    logic [TW-1:0]      other_next;
    logic [SW-1:0]      slot_reg;
    logic [SW-1:0]      slot_next;
    logic [TW-1:0]      cnt_reg;
    logic [TW-1:0]      cnt_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    vct_pkg::out_word_t rsp_word_reg;
    vct_pkg::out_word_t rsp_word_next;

    logic [TW-1:0] thr_lut [8];
    logic [SW-1:0] slot_lut [16];

    logic          accept;
    logic          go;
    logic          emit;
    logic          emit_last;
    logic [TW-1:0] emit_thread;
    logic [CLOCK_BITS-1:0] emit_val;
    logic [CLOCK_BITS+31:0] val_ext;
    logic [TW+2:0] thr_ext;

    logic          ct_re;
    logic          ct_we;
    logic [TW-1:0] ct_waddr;
    logic [RW-1:0] ct_rdata_a;
    logic [RW-1:0] ct_rdata_b;
    logic          ss_we;
    logic [RW-1:0] ss_rdata;

    vct_pkg::row_ctl_t ctl;
    logic [TW-1:0]     bump_idx;
    logic [RW-1:0]     row_b;
    logic [RW-1:0]     row_new;

    for (genvar g = 0; g < 8; g++)
    begin : g_thr_lut
        assign thr_lut[g] = TW'(g % THREADS);
    end

    for (genvar g = 0; g < 16; g++)
    begin : g_slot_lut
        assign slot_lut[g] = SW'(g % COND_SLOTS);
    end

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign go        = !rsp_valid_reg || rsp_ready;
    assign ct_re     = accept;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    vct_state_mem #(
        .THREADS    (THREADS),
        .COND_SLOTS (COND_SLOTS),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ct_re      (ct_re),
        .ct_raddr_a (thr_lut[req_word.actor_thread]),
        .ct_raddr_b (thr_lut[req_word.other_thread]),
        .ct_rdata_a (ct_rdata_a),
        .ct_rdata_b (ct_rdata_b),
        .ct_we      (ct_we),
        .ct_waddr   (ct_waddr),
        .ct_wdata   (row_new),
        .ss_re      (accept),
        .ss_raddr   (slot_lut[req_word.cond_slot]),
        .ss_rdata   (ss_rdata),
        .ss_we      (ss_we),
        .ss_waddr   (slot_reg),
        .ss_wdata   (ct_rdata_a)
    );

    vct_row_unit #(
        .THREADS    (THREADS),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_row (
        .ctl      (ctl),
        .bump_idx (bump_idx),
        .row_a    (ct_rdata_a),
        .row_b    (row_b),
        .row_new  (row_new)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        actor_next  = actor_reg;
        other_next  = other_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        ct_we       = 1'b0;
        ct_waddr    = actor_reg;
        ss_we       = 1'b0;
        ctl         = '0;
        bump_idx    = actor_reg;
        row_b       = ct_rdata_b;
        emit        = 1'b0;
        emit_last   = 1'b1;
        emit_thread = actor_reg;
        emit_val    = row_new[actor_reg*CLOCK_BITS +: CLOCK_BITS];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req_word.operation;
                    actor_next = thr_lut[req_word.actor_thread];
                    other_next = thr_lut[req_word.other_thread];
                    slot_next  = slot_lut[req_word.cond_slot];
                    cnt_next   = '0;
                    unique case (req_word.operation) inside
                        vct_pkg::OP_JOIN, vct_pkg::OP_SIGNAL,
                        vct_pkg::OP_WAIT, vct_pkg::OP_CREATE: state_next = S_EXEC;
                        vct_pkg::OP_READ:                     state_next = S_READ;
                        default:                              state_next = S_IDLE;
                    endcase
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    vct_pkg::OP_JOIN:
                    begin
                        ctl.merge = 1'b1;
                        if (go)
                        begin
                            ct_we      = 1'b1;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    vct_pkg::OP_SIGNAL:
                    begin
                        ctl.bump = 1'b1;
                        if (go)
                        begin
                            ct_we      = 1'b1;
                            ss_we      = 1'b1;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    vct_pkg::OP_WAIT:
                    begin
                        ctl.merge = 1'b1;
                        row_b     = ss_rdata;
                        if (go)
                        begin
                            ct_we      = 1'b1;
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    vct_pkg::OP_CREATE:
                    begin
                        ctl.bump = 1'b1;
                        if (other_reg == actor_reg)
                        begin
                            ctl.bump_twice = 1'b1;
                            if (go)
                            begin
                                ct_we      = 1'b1;
                                emit       = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            bump_idx   = other_reg;
                            ct_waddr   = other_reg;
                            ct_we      = 1'b1;
                            state_next = S_CREATE2;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CREATE2:
            begin
                ctl.bump = 1'b1;
                if (go)
                begin
                    ct_we      = 1'b1;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                emit_thread = cnt_reg;
                emit_val    = ct_rdata_a[cnt_reg*CLOCK_BITS +: CLOCK_BITS];
                emit_last   = (cnt_reg == TW'(THREADS - 1));
                if (go)
                begin
                    emit = 1'b1;
                    if (emit_last)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign val_ext = {32'd0, emit_val};
    assign thr_ext = {3'd0, emit_thread};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_word_next  = rsp_word_reg;
        if (emit)
        begin
            rsp_valid_next             = 1'b1;
            rsp_word_next.entry_thread = thr_ext[2:0];
            rsp_word_next.clock_value  = val_ext[31:0];
            rsp_word_next.last         = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        actor_reg    <= actor_next;
        other_reg    <= other_next;
        slot_reg     <= slot_next;
        rsp_word_reg <= rsp_word_next;
    end

    `VCT_ASSERT_NOW(a_no_read_on_write, ct_we, !ct_re, "clock table read during write-back")
    `VCT_ASSERT_NEXT(a_read_enters_sweep,
        accept && (req_word.operation == vct_pkg::OP_READ),
        state_reg == S_READ, "read word did not start the entry sweep")
    `VCT_ASSERT_NEXT(a_sweep_holds_on_stall,
        (state_reg == S_READ) && rsp_valid_reg && !rsp_ready,
        (state_reg == S_READ) && $stable(cnt_reg), "entry sweep advanced under stall")

endmodule
